// ----- hdl/ntmp_pkg.sv -----
// Package for the next-task Markov predictor.
// Field widths, hash constants, op and register codes, table entry type.
// No dependencies.
package ntmp_pkg;

	localparam int ID_W    = 16;
	localparam int TRIG_W  = 8;
	localparam int OP_W    = 2;
	localparam int CNT_W   = 16;
	localparam int STAT_W  = 32;
	localparam int CFG_W   = 8;
	localparam int CONF_W  = 4;

	localparam logic [31:0] HASH_ID_MUL   = 32'd2654435761;
	localparam logic [31:0] HASH_TRIG_MUL = 32'd16777619;
	localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
	localparam logic [7:0] MIN_SAMPLES_RST = 8'd4;
	localparam logic [CONF_W-1:0] CONF_RST = 4'd6;
	localparam int CONF_SCALE = 10;

	typedef enum logic [OP_W-1:0] {
		OP_RECORD  = 2'd0,
		OP_PREDICT = 2'd1,
		OP_CLEAR   = 2'd2
	} ntmp_op_t;

	typedef enum logic {
		CFG_MIN_SAMPLES = 1'b0,
		CFG_CONFIDENCE  = 1'b1
	} ntmp_cfg_idx_t;

	typedef struct packed {
		logic [ID_W-1:0]  succ;
		logic [CNT_W-1:0] count;
	} ntmp_entry_t;

endpackage

// ----- hdl/ntmp_req_if.sv -----
// Request channel of the next-task Markov predictor.
// Depends on ntmp_pkg for field widths.
interface ntmp_req_if import ntmp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [ID_W-1:0]   from_id;
	logic [ID_W-1:0]   to_id;
	logic [TRIG_W-1:0] trigger;

	modport source (output valid, op, from_id, to_id, trigger, input ready);
	modport sink (input valid, op, from_id, to_id, trigger, output ready);
endinterface

// ----- hdl/ntmp_rsp_if.sv -----
// Response channel of the next-task Markov predictor.
// Depends on ntmp_pkg for field widths.
interface ntmp_rsp_if import ntmp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ID_W-1:0]   predicted_id;
	logic              prediction_given;
	logic [STAT_W-1:0] scored_total;
	logic [STAT_W-1:0] scored_correct;

	modport source (output valid, predicted_id, prediction_given, scored_total,
		scored_correct, input ready);
	modport sink (input valid, predicted_id, prediction_given, scored_total,
		scored_correct, output ready);
endinterface

// ----- hdl/ntmp_hash.sv -----
// Bucket hash unit: multiply-xor hash, then modulo BUCKETS eight bits a cycle.
// Depends on ntmp_pkg.
module ntmp_hash import ntmp_pkg::*; #(
	parameter int BUCKETS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ID_W-1:0]            from_id,
	input  logic [TRIG_W-1:0]          trigger,
	output logic                       done,
	output logic [$clog2(BUCKETS)-1:0] bucket
);

	localparam int BKT_W  = $clog2(BUCKETS);
	localparam int DIGIT  = 8;
	localparam int STEPS  = 32 / DIGIT;
	localparam int STEP_W = $clog2(STEPS);

	logic [31:0]       hash_q;
	logic [31:0]       hash_init;
	logic [BKT_W-1:0]  rem_q;
	logic [BKT_W-1:0]  rem_next;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	always_comb begin
		logic [31:0] id_prod;
		logic [31:0] trig_prod;
		id_prod   = {16'd0, from_id} * HASH_ID_MUL;
		trig_prod = {24'd0, trigger} * HASH_TRIG_MUL;
		hash_init = id_prod ^ trig_prod;
	end

	always_comb begin
		logic [BKT_W:0]   t;
		logic [BKT_W-1:0] r;
		r = rem_q;
		for (int k = 0; k < DIGIT; k++) begin
			t = {r, hash_q[31-k]};
			if (t >= (BKT_W+1)'(BUCKETS)) begin
				t = t - (BKT_W+1)'(BUCKETS);
			end
			r = t[BKT_W-1:0];
		end
		rem_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !start && busy_q && (step_q == STEP_W'(STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hash_q <= hash_init;
			rem_q  <= '0;
		end else if (busy_q) begin
			hash_q <= {hash_q[31-DIGIT:0], {DIGIT{1'b0}}};
			rem_q  <= rem_next;
		end
	end

	assign done   = done_q;
	assign bucket = rem_q;

endmodule

// ----- hdl/next_task_markov_predictor.sv -----
// Next-task Markov predictor: a BUCKETS x WAYS table of (successor, count) entries,
// indexed by a hash of the task id and trigger. Depends on ntmp_pkg, ntmp_req_if,
// ntmp_rsp_if and ntmp_hash.
//
// In a record or predict transaction, from acceptance until the block is ready again,
// the hash is formed as the request is accepted, the hash unit reduces it modulo
// BUCKETS eight bits a cycle, the row is read into a register, each way in turn goes
// through the shared compare/add unit, the row is written back or the confidence is
// tested, and the response register is loaded once it is free. A clear transaction
// zeroes the table one row a cycle and then answers. After reset the same pass runs
// before the first request is accepted; configuration writes are taken throughout.
// An op code of 3 goes straight to the response step and changes nothing. The response
// sits in an output register, so a new request is accepted while the previous response
// waits.
module next_task_markov_predictor import ntmp_pkg::*; #(
	parameter int BUCKETS = 64,
	parameter int WAYS    = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	ntmp_req_if.sink   req,
	ntmp_rsp_if.source rsp,
	input  logic       cfg_wr_en,
	input  logic       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int BKT_W  = $clog2(BUCKETS);
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SUM_W  = $clog2(WAYS * 65535 + 1);
	localparam int PROD_W = SUM_W + CONF_W;

	typedef enum logic [8:0] {
		S_SWEEP  = 9'b000000001,
		S_IDLE   = 9'b000000010,
		S_HASH   = 9'b000000100,
		S_SCAN   = 9'b000001000,
		S_WRITE  = 9'b000010000,
		S_DECIDE = 9'b000100000,
		S_DONE   = 9'b001000000,
		S_FLUSH  = 9'b010000000,
		S_SPARE  = 9'b100000000
	} state_t;

	state_t state_q;

	ntmp_entry_t [WAYS-1:0] mem_q [BUCKETS];
	ntmp_entry_t [WAYS-1:0] row_q;
	ntmp_entry_t [WAYS-1:0] wr_row;
	logic                   mem_we;
	logic [BKT_W-1:0]       mem_waddr;
	ntmp_entry_t [WAYS-1:0] mem_wdata;

	logic [BKT_W-1:0]  sweep_q;
	logic              clr_rsp_q;
	logic [OP_W-1:0]   op_q;
	logic [ID_W-1:0]   from_q;
	logic [ID_W-1:0]   to_q;
	logic [ID_W-1:0]   pred_q;

	logic [7:0]        min_samples_q;
	logic [CONF_W-1:0] conf_q;

	logic [ID_W-1:0]   pend_from_q;
	logic [ID_W-1:0]   pend_guess_q;
	logic [STAT_W-1:0] total_q;
	logic [STAT_W-1:0] correct_q;

	logic [WAY_W-1:0]  way_q;
	logic              found_q;
	logic [WAY_W-1:0]  hit_slot_q;
	logic [CNT_W-1:0]  hit_cnt_q;
	logic              have_empty_q;
	logic [WAY_W-1:0]  vacant_way_q;
	logic [CNT_W-1:0]  min_cnt_q;
	logic [WAY_W-1:0]  low_way_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  best_cnt_q;
	logic [ID_W-1:0]   best_id_q;

	logic              out_valid_q;
	logic [ID_W-1:0]   out_pred_q;
	logic [STAT_W-1:0] out_total_q;
	logic [STAT_W-1:0] out_correct_q;

	logic              req_fire;
	logic              hash_done;
	logic [BKT_W-1:0]  hash_bucket;
	logic              out_free;
	ntmp_entry_t       cur;
	logic              pass;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign cur       = row_q[way_q];

	ntmp_hash #(
		.BUCKETS (BUCKETS)
	) u_hash (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (req_fire && (req.op == OP_RECORD || req.op == OP_PREDICT)),
		.from_id (req.from_id),
		.trigger (req.trigger),
		.done    (hash_done),
		.bucket  (hash_bucket)
	);

	always_comb begin
		logic [WAY_W-1:0] slot;
		wr_row = row_q;
		slot   = found_q ? hit_slot_q : (have_empty_q ? vacant_way_q : low_way_q);
		wr_row[slot].succ = to_q;
		if (found_q) begin
			wr_row[slot].count = (hit_cnt_q == COUNT_MAX) ? COUNT_MAX : hit_cnt_q + 1'b1;
		end else begin
			wr_row[slot].count = CNT_W'(1);
		end
	end

	always_comb begin
		logic [PROD_W-1:0] lhs;
		logic [PROD_W-1:0] rhs;
		lhs  = PROD_W'(best_cnt_q) * PROD_W'(CONF_SCALE);
		rhs  = PROD_W'(sum_q) * PROD_W'(conf_q);
		pass = (sum_q >= SUM_W'(min_samples_q)) && (lhs >= rhs);
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = hash_bucket;
		mem_wdata = wr_row;
		if (state_q == S_SWEEP) begin
			mem_we    = 1'b1;
			mem_waddr = sweep_q;
			mem_wdata = '0;
		end else if (state_q == S_WRITE) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (state_q == S_HASH && hash_done) begin
			row_q <= mem_q[hash_bucket];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_samples_q <= MIN_SAMPLES_RST;
			conf_q        <= CONF_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_MIN_SAMPLES: min_samples_q <= cfg_wdata;
				CFG_CONFIDENCE:  conf_q        <= cfg_wdata[CONF_W-1:0];
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_SWEEP;
			sweep_q       <= '0;
			clr_rsp_q     <= 1'b0;
			pend_from_q   <= '0;
			pend_guess_q  <= '0;
			total_q       <= '0;
			correct_q     <= '0;
			out_valid_q   <= 1'b0;
			way_q         <= '0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_SWEEP: begin
					if (sweep_q == BKT_W'(BUCKETS - 1)) begin
						sweep_q <= '0;
						state_q <= clr_rsp_q ? S_DONE : S_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						unique case (req.op)
							OP_RECORD: begin
								if (pend_guess_q != '0 && pend_from_q == req.from_id) begin
									if (total_q != '1) begin
										total_q <= total_q + 1'b1;
									end
									if (pend_guess_q == req.to_id && correct_q != '1) begin
										correct_q <= correct_q + 1'b1;
									end
									pend_guess_q <= '0;
								end
								state_q <= S_HASH;
							end
							OP_PREDICT: state_q <= S_HASH;
							OP_CLEAR: begin
								pend_from_q  <= '0;
								pend_guess_q <= '0;
								total_q      <= '0;
								correct_q    <= '0;
								clr_rsp_q    <= 1'b1;
								state_q      <= S_SWEEP;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_HASH: begin
					if (hash_done) begin
						way_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					way_q <= way_q + 1'b1;
					if (way_q == WAY_W'(WAYS - 1)) begin
						state_q <= (op_q == OP_RECORD) ? S_WRITE : S_DECIDE;
					end
				end
				S_WRITE: state_q <= S_DONE;
				S_DECIDE: begin
					if (pass) begin
						pend_from_q  <= from_q;
						pend_guess_q <= best_id_q;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						clr_rsp_q   <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q   <= req.op;
			from_q <= req.from_id;
			to_q   <= req.to_id;
			pred_q <= '0;
		end
		if (state_q == S_HASH && hash_done) begin
			found_q      <= 1'b0;
			hit_slot_q   <= '0;
			hit_cnt_q    <= '0;
			have_empty_q <= 1'b0;
			vacant_way_q <= '0;
			min_cnt_q    <= COUNT_MAX;
			low_way_q    <= '0;
			sum_q        <= '0;
			best_cnt_q   <= '0;
			best_id_q    <= '0;
		end
		if (state_q == S_SCAN) begin
			sum_q <= sum_q + SUM_W'(cur.count);
			if (cur.count > best_cnt_q) begin
				best_cnt_q <= cur.count;
				best_id_q  <= cur.succ;
			end
			if (!found_q) begin
				if (cur.count == '0) begin
					if (!have_empty_q) begin
						have_empty_q <= 1'b1;
						vacant_way_q <= way_q;
					end
				end else if (cur.succ == to_q) begin
					found_q    <= 1'b1;
					hit_slot_q <= way_q;
					hit_cnt_q  <= cur.count;
				end else if (cur.count < min_cnt_q) begin
					min_cnt_q  <= cur.count;
					low_way_q  <= way_q;
				end
			end
		end
		if (state_q == S_DECIDE && pass) begin
			pred_q <= best_id_q;
		end
		if (state_q == S_DONE && out_free) begin
			out_pred_q    <= pred_q;
			out_total_q   <= total_q;
			out_correct_q <= correct_q;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.predicted_id     = out_pred_q;
	assign rsp.prediction_given = (out_pred_q != '0);
	assign rsp.scored_total     = out_total_q;
	assign rsp.scored_correct   = out_correct_q;

endmodule
